[rtl/px2x_pkg.sv]
// ----------------------------------------------------------------------------
// px2x_pkg: shared types and constants for the 2x pixel-art upscaler
// Register indexes, defaults and the front-to-back control word.
// ----------------------------------------------------------------------------
package px2x_pkg;

    localparam int PIXEL_BITS_DEF = 16;
    localparam int LINE_MAX_DEF   = 512;
    localparam int CFG_BITS       = 16;
    localparam int CNT_BITS       = 10;
    localparam int ROW_BITS       = 11;
    localparam int FILL_BITS      = 11;

    localparam logic [1:0] REG_WIDE_MODE   = 2'd0;
    localparam logic [1:0] REG_LINE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_FRAME_LINES = 2'd2;
    localparam logic [1:0] REG_BLEND_MASK  = 2'd3;

    localparam logic [9:0]  WIDTH_RESET = 10'd256;
    localparam logic [9:0]  LINES_RESET = 10'd212;
    localparam logic [15:0] MASK_RESET  = 16'd63454;

    // Per-item control passed from the front to the back.
    typedef struct packed {
        logic       emit;
        logic       border;
        logic       eol;
        logic       eof;
    } px2x_ctl_t;

endpackage

[rtl/px2x_front.sv]
// ----------------------------------------------------------------------------
// px2x_front: line stores, window and position tracking
// Accepts source words, reads the column of four rows and keeps the 4x4
// window; issues one window word per emitting item to the back.
// ----------------------------------------------------------------------------
module px2x_front #(
    parameter int PIXEL_BITS = px2x_pkg::PIXEL_BITS_DEF,
    parameter int LINE_MAX   = px2x_pkg::LINE_MAX_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [15:0]               pixel,
    input  logic                      flush,
    input  logic                      wide_mode,
    input  logic [9:0]                line_width,
    input  logic [9:0]                frame_lines,
    output logic                      win_valid,
    input  logic                      win_ready,
    output logic [16*PIXEL_BITS-1:0]  win,
    output px2x_pkg::px2x_ctl_t       win_ctl
);
    localparam int AW = $clog2(LINE_MAX);

    // Stage 0: counters; memory read issued. Stage 1: window shift.
    // One bank per row mod 3; a taken word reads all three and, unless draining, writes the current row's bank.
    logic [PIXEL_BITS-1:0] mem0 [LINE_MAX];
    logic [PIXEL_BITS-1:0] mem1 [LINE_MAX];
    logic [PIXEL_BITS-1:0] mem2 [LINE_MAX];

    logic [9:0]                   col_reg;
    logic [px2x_pkg::ROW_BITS-1:0] row_reg;
    logic [px2x_pkg::FILL_BITS-1:0] fill_reg;
    logic [9:0]                   ocol_reg;
    logic [px2x_pkg::ROW_BITS-1:0] orow_reg;
    logic [1:0]                   rmod_reg;   // row_reg % 3

    logic [10:0] w_eff;
    logic [10:0] h_eff;
    always_comb
    begin
        if (line_width < 10'd4)
            w_eff = 11'd4;
        else if (int'(line_width) > LINE_MAX)
            w_eff = 11'(LINE_MAX);
        else
            w_eff = {1'b0, line_width};
        h_eff = (frame_lines < 10'd4) ? 11'd4 : {1'b0, frame_lines};
    end

    // Stage 1 holding and downstream stall
    logic        s1_valid_reg;
    px2x_pkg::px2x_ctl_t   s1_ctl_reg;
    logic        stall;
    assign stall    = s1_valid_reg && s1_ctl_reg.emit && !win_ready;
    assign in_ready = !stall;

    logic        acc;
    assign acc = in_valid && in_ready;

    // Column wrap
    logic [9:0]                    col_w;
    logic [px2x_pkg::ROW_BITS-1:0] row_w;
    logic [1:0]                    rmod_w;
    always_comb
    begin
        col_w  = col_reg;
        row_w  = row_reg;
        rmod_w = rmod_reg;
        if ({1'b0, col_reg} >= w_eff)
        begin
            col_w = '0;
            if (row_reg < 11'd2047)
            begin
                row_w  = row_reg + 11'd1;
                rmod_w = (rmod_reg == 2'd2) ? 2'd0 : rmod_reg + 2'd1;
            end
        end
    end

    logic drain;
    assign drain = row_w >= h_eff;
    logic take;
    assign take = acc && !(flush && !drain);

    // Source rows r-3..r, clamped; row index mod 3 per tap
    logic [1:0]  tap_mod [4];
    logic        tap_live [4];
    always_comb
    begin
        logic signed [12:0] rr;
        logic [10:0]        ru;
        for (int k = 0; k < 4; k++)
        begin
            rr = $signed({2'b00, row_w}) - 13'sd3 + 13'(k);
            if (rr < 0)
                rr = '0;
            if (rr > $signed({2'b00, h_eff}) - 13'sd1)
                rr = $signed({2'b00, h_eff}) - 13'sd1;
            ru = rr[10:0];
            tap_live[k] = !drain && (ru == row_w);
            // ru within row_w-3..row_w: map via offset from row_w
            case (2'(row_w - ru))
                2'd0: tap_mod[k] = rmod_w;
                2'd1: tap_mod[k] = (rmod_w == 2'd0) ? 2'd2 : rmod_w - 2'd1;
                2'd2: tap_mod[k] = (rmod_w == 2'd2) ? 2'd0 : rmod_w + 2'd1;
                default: tap_mod[k] = rmod_w;
            endcase
            if (row_w - ru > 11'd3)
                tap_mod[k] = rmod_w;
        end
    end

    // Read the three stores (row r-3 == r mod 3 only when live or clamped)
    logic [PIXEL_BITS-1:0] rd_reg [3];
    logic [1:0]            s1_mod_reg [4];
    logic                  s1_live_reg [4];
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    logic [AW-1:0]         col_idx;
    assign col_idx = AW'(col_w);

    // Write happens in stage 0; read of same row same column is bypassed by live.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rd_reg[0] <= mem0[col_idx];
            rd_reg[1] <= mem1[col_idx];
            rd_reg[2] <= mem2[col_idx];
            if (!drain)
            begin
                case (rmod_w)
                    2'd0: mem0[col_idx] <= PIXEL_BITS'(pixel);
                    2'd1: mem1[col_idx] <= PIXEL_BITS'(pixel);
                    default: mem2[col_idx] <= PIXEL_BITS'(pixel);
                endcase
            end
        end
    end

    // Output position and emit
    logic                          emit;
    logic                          eol;
    logic                          eof;
    assign emit = {1'b0, fill_reg} >= {w_eff, 1'b0} + 12'd2;
    assign eol  = {1'b0, ocol_reg} + 11'd1 >= w_eff;
    assign eof  = eol && (orow_reg + 11'd1 >= h_eff);

    logic border;
    always_comb
    begin
        if (wide_mode)
            border = (ocol_reg == '0) || eol;
        else
            border = (ocol_reg == '0) || ({1'b0, ocol_reg} + 11'd2 >= w_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            rmod_reg     <= '0;
            fill_reg     <= '0;
            ocol_reg     <= '0;
            orow_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (!stall)
                s1_valid_reg <= take;
            if (take)
            begin
                if (emit && eof)
                begin
                    col_reg  <= '0;
                    row_reg  <= '0;
                    rmod_reg <= '0;
                    fill_reg <= '0;
                    ocol_reg <= '0;
                    orow_reg <= '0;
                end
                else
                begin
                    col_reg  <= col_w + 10'd1;
                    row_reg  <= row_w;
                    rmod_reg <= rmod_w;
                    if (fill_reg < 11'd2047)
                        fill_reg <= fill_reg + 11'd1;
                    if (emit)
                    begin
                        if (eol)
                        begin
                            ocol_reg <= '0;
                            orow_reg <= orow_reg + 11'd1;
                        end
                        else
                            ocol_reg <= ocol_reg + 10'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_pix_reg <= PIXEL_BITS'(pixel);
            s1_ctl_reg <= '{emit: emit, border: border, eol: eol, eof: eof};
            for (int k = 0; k < 4; k++)
            begin
                s1_mod_reg[k]  <= tap_mod[k];
                s1_live_reg[k] <= tap_live[k];
            end
        end
    end

    // Window: rows k, columns 0..3; shifted when stage 1 moves on
    logic [PIXEL_BITS-1:0] win_reg [4][4];
    logic [PIXEL_BITS-1:0] colv [4];
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (s1_live_reg[k])
                colv[k] = s1_pix_reg;
            else
                case (s1_mod_reg[k])
                    2'd0: colv[k] = rd_reg[0];
                    2'd1: colv[k] = rd_reg[1];
                    default: colv[k] = rd_reg[2];
                endcase
        end
    end

    logic [PIXEL_BITS-1:0] nwin [4][4];
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            nwin[k][0] = win_reg[k][1];
            nwin[k][1] = win_reg[k][2];
            nwin[k][2] = win_reg[k][3];
            nwin[k][3] = colv[k];
        end
    end

    // Window register is shifted once when stage 1 hands over.
    // A non-emitting stage-1 word never stalls.
    logic shift;
    assign shift = s1_valid_reg && !stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 4; k++)
                for (int j = 0; j < 4; j++)
                    win_reg[k][j] <= '0;
        end
        else if (shift)
            win_reg <= nwin;
    end

    assign win_valid = s1_valid_reg && s1_ctl_reg.emit;
    assign win_ctl   = s1_ctl_reg;
    always_comb
    begin
        for (int k = 0; k < 4; k++)
            for (int j = 0; j < 4; j++)
                win[(k*4+j)*PIXEL_BITS +: PIXEL_BITS] = nwin[k][j];
    end
endmodule

[rtl/px2x_back.sv]
// ----------------------------------------------------------------------------
// px2x_back: 2xSaI edge rules and blends
// Compares, selection and blend in one combinational stage ahead of a
// skid-free output register driven by downstream ready.
// ----------------------------------------------------------------------------
module px2x_back #(
    parameter int PIXEL_BITS = px2x_pkg::PIXEL_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      win_valid,
    output logic                      win_ready,
    input  logic [16*PIXEL_BITS-1:0]  win,
    input  px2x_pkg::px2x_ctl_t       win_ctl,
    input  logic                      wide_mode,
    input  logic [15:0]               blend_mask,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [15:0]               top_left,
    output logic [15:0]               top_right,
    output logic [15:0]               bottom_left,
    output logic [15:0]               bottom_right,
    output logic                      end_of_line,
    output logic                      end_of_frame
);
    localparam int PB = PIXEL_BITS;

    function automatic logic [PB-1:0] mix(logic [PB-1:0] a, logic [PB-1:0] b,
                                          logic [PB-1:0] m);
        mix = ((a & m) >> 1) + ((b & m) >> 1) + (a & b & ~m);
    endfunction

    function automatic logic signed [2:0] vote(logic [PB-1:0] p, logic [PB-1:0] q,
                                              logic [PB-1:0] a, logic [PB-1:0] b);
        if (p != q)
            vote = 3'sd0;
        else if (a == p)
            vote = -3'sd1;
        else if (b == p)
            vote = 3'sd1;
        else
            vote = 3'sd0;
    endfunction

    logic [PB-1:0] m;
    assign m = PB'(blend_mask);

    logic [PB-1:0] w [16];
    always_comb
    begin
        for (int i = 0; i < 16; i++)
            w[i] = win[i*PB +: PB];
    end

    logic [PB-1:0] tr, bl, br;
    always_comb
    begin
        logic [PB-1:0] I, E, F, J, G, A, B, K, H, C, D, L, M, N, O;
        logic signed [3:0] r;
        I = w[0];  E = w[1];  F = w[2];  J = w[3];
        G = w[4];  A = w[5];  B = w[6];  K = w[7];
        H = w[8];  C = w[9];  D = w[10]; L = w[11];
        M = w[12]; N = w[13]; O = w[14];
        r = '0;
        if (A == D && B != C)
        begin
            tr = ((A == E && B == L) || (A == C && A == F && B != E && B == J)) ? A : mix(A, B, m);
            bl = ((A == G && C == O) || (A == B && A == H && G != C && C == M)) ? A : mix(A, C, m);
            br = A;
        end
        else if (B == C && A != D)
        begin
            tr = ((B == F && A == H) || (B == E && B == D && A != F && A == I)) ? B : mix(A, B, m);
            bl = ((C == H && A == F) || (C == G && C == D && A != H && A == I)) ? C : mix(A, C, m);
            br = B;
        end
        else if (A == D && B == C)
        begin
            if (A == B)
            begin
                tr = A; bl = A; br = A;
            end
            else
            begin
                r = 4'(vote(E, G, A, B)) + 4'(vote(F, K, A, B))
                  + 4'(vote(H, N, A, B)) + 4'(vote(L, O, A, B));
                tr = mix(A, B, m);
                bl = tr;
                br = (r > 0) ? A : ((r < 0) ? B : tr);
            end
        end
        else
        begin
            tr = (A == C && A == F && B != E && B == J) ? A
               : ((B == E && B == D && A != F && A == I) ? B : mix(A, B, m));
            bl = (A == B && A == H && G != C && C == M) ? A
               : ((C == G && C == D && A != H && A == I) ? C : mix(A, C, m));
            br = mix(mix(A, B, m), mix(C, D, m), m);
        end
        if (wide_mode)
        begin
            if (win_ctl.border)
                bl = mix(A, C, m);
            tr = '0;
            br = '0;
        end
        else if (win_ctl.border)
        begin
            tr = A; bl = A; br = A;
        end
    end

    logic out_valid_reg;
    assign win_ready = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (win_ready)
            out_valid_reg <= win_valid;
    end

    always_ff @(posedge clk)
    begin
        if (win_ready && win_valid)
        begin
            top_left     <= 16'(w[5]);
            top_right    <= 16'(tr);
            bottom_left  <= 16'(bl);
            bottom_right <= 16'(br);
            end_of_line  <= win_ctl.eol;
            end_of_frame <= win_ctl.eof;
        end
    end
endmodule

[rtl/pixel_art_2x_upscaler_unit.sv]
// Path: a result word passes the front's stage-1 registers and then the back's output register;
// results lag the source by two lines and two pixels.
// Throughput: one word per cycle unless out_ready stalls; all three banks read, one written unless draining.
// Reset: counters, window and config registers clear to their defaults; the
// line store is not cleared and needs no pass.
// ----------------------------------------------------------------------------
// pixel_art_2x_upscaler_unit: 2x pixel-art upscaler top level
// Configuration registers, front (line stores, window) and back (edge rules).
// ----------------------------------------------------------------------------
module pixel_art_2x_upscaler_unit #(
    parameter int PIXEL_BITS = px2x_pkg::PIXEL_BITS_DEF,
    parameter int LINE_MAX   = px2x_pkg::LINE_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] pixel,
    input  logic        flush,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] top_left,
    output logic [15:0] top_right,
    output logic [15:0] bottom_left,
    output logic [15:0] bottom_right,
    output logic        end_of_line,
    output logic        end_of_frame
);
    logic        wide_reg;
    logic [9:0]  width_reg;
    logic [9:0]  lines_reg;
    logic [15:0] mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_reg  <= 1'b0;
            width_reg <= px2x_pkg::WIDTH_RESET;
            lines_reg <= px2x_pkg::LINES_RESET;
            mask_reg  <= px2x_pkg::MASK_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                px2x_pkg::REG_WIDE_MODE:   wide_reg  <= cfg_data[0];
                px2x_pkg::REG_LINE_WIDTH:  width_reg <= cfg_data[9:0];
                px2x_pkg::REG_FRAME_LINES: lines_reg <= cfg_data[9:0];
                px2x_pkg::REG_BLEND_MASK:  mask_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    logic                       win_valid;
    logic                       win_ready;
    logic [16*PIXEL_BITS-1:0]   win;
    px2x_pkg::px2x_ctl_t        win_ctl;

    px2x_front #(.PIXEL_BITS(PIXEL_BITS), .LINE_MAX(LINE_MAX)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel       (pixel),
        .flush       (flush),
        .wide_mode   (wide_reg),
        .line_width  (width_reg),
        .frame_lines (lines_reg),
        .win_valid   (win_valid),
        .win_ready   (win_ready),
        .win         (win),
        .win_ctl     (win_ctl)
    );

    px2x_back #(.PIXEL_BITS(PIXEL_BITS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .win_valid    (win_valid),
        .win_ready    (win_ready),
        .win          (win),
        .win_ctl      (win_ctl),
        .wide_mode    (wide_reg),
        .blend_mask   (mask_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .top_left     (top_left),
        .top_right    (top_right),
        .bottom_left  (bottom_left),
        .bottom_right (bottom_right),
        .end_of_line  (end_of_line),
        .end_of_frame (end_of_frame)
    );
endmodule

[dv/px2x_block_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// px2x_block_checker: predicts and checks the 2x upscaler output blocks
// Watches the register port and both channels, keeps its own line stores,
// window and counters, queues the expected 2x2 blocks and compares each
// accepted output word with the oldest one.
// ----------------------------------------------------------------------------
module px2x_block_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [15:0] pixel,
    input  logic        flush,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] top_left,
    input  logic [15:0] top_right,
    input  logic [15:0] bottom_left,
    input  logic [15:0] bottom_right,
    input  logic        end_of_line,
    input  logic        end_of_frame,
    output int          errors,
    output int          pending
);

    localparam int LMAX = px2x_pkg::LINE_MAX_DEF;

    typedef struct {
        logic [15:0] tl;
        logic [15:0] tr;
        logic [15:0] bl;
        logic [15:0] br;
        logic        eol;
        logic        eof;
    } block_t;

    block_t      expected_blocks[$];

    logic        wide;
    logic [9:0]  width_reg;
    logic [9:0]  lines_reg;
    logic [15:0] mask_reg;

    logic [15:0] line_mem [3*LMAX];
    logic [15:0] win [4][4];
    int          col_cnt;
    int          row_cnt;
    int          fill_cnt;
    int          out_col;
    int          out_row;

    initial errors = 0;

    function automatic logic [15:0] blend(logic [15:0] a, logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, (a & mask_reg) >> 1} + {1'b0, (b & mask_reg) >> 1}
            + {1'b0, a & b & ~mask_reg};
        return s[15:0];
    endfunction

    function automatic int vote(logic [15:0] p, logic [15:0] q, logic [15:0] a,
                                logic [15:0] b);
        if (p != q) return 0;
        if (a == p) return -1;
        if (b == p) return 1;
        return 0;
    endfunction

    task automatic predict_block(logic [15:0] p, logic f);
        int          wd;
        int          ht;
        int          rr;
        int          vsum;
        logic        drain;
        logic        emit;
        logic [15:0] colv [4];
        logic [15:0] I, E, F, J, G, A, B, K, H, C, D, L, M, N, O;
        block_t      blk;
        wd = (width_reg < 4) ? 4 : ((width_reg > LMAX) ? LMAX : int'(width_reg));
        ht = (lines_reg < 4) ? 4 : int'(lines_reg);
        if (col_cnt >= wd) begin
            col_cnt = 0;
            if (row_cnt < 2047) row_cnt++;
        end
        drain = (row_cnt >= ht);
        if (f && !drain) return;   // flush inside the frame is ignored
        for (int k = 0; k < 4; k++) begin
            rr = row_cnt - 3 + k;
            if (rr < 0) rr = 0;
            if (rr > ht - 1) rr = ht - 1;
            if (!drain && rr == row_cnt)
                colv[k] = p;
            else
                colv[k] = line_mem[(rr % 3) * LMAX + (col_cnt % LMAX)];
        end
        for (int k = 0; k < 4; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
            win[k][2] = win[k][3];
            win[k][3] = colv[k];
        end
        if (!drain)
            line_mem[(row_cnt % 3) * LMAX + (col_cnt % LMAX)] = p;
        emit = (fill_cnt >= 2 * wd + 2);
        col_cnt++;
        if (fill_cnt < 2047) fill_cnt++;
        if (!emit) return;

        I = win[0][0]; E = win[0][1]; F = win[0][2]; J = win[0][3];
        G = win[1][0]; A = win[1][1]; B = win[1][2]; K = win[1][3];
        H = win[2][0]; C = win[2][1]; D = win[2][2]; L = win[2][3];
        M = win[3][0]; N = win[3][1]; O = win[3][2];
        blk.tl = A;
        if (A == D && B != C) begin
            blk.tr = ((A == E && B == L) || (A == C && A == F && B != E && B == J))
                     ? A : blend(A, B);
            blk.bl = ((A == G && C == O) || (A == B && A == H && G != C && C == M))
                     ? A : blend(A, C);
            blk.br = A;
        end else if (B == C && A != D) begin
            blk.tr = ((B == F && A == H) || (B == E && B == D && A != F && A == I))
                     ? B : blend(A, B);
            blk.bl = ((C == H && A == F) || (C == G && C == D && A != H && A == I))
                     ? C : blend(A, C);
            blk.br = B;
        end else if (A == D && B == C) begin
            if (A == B) begin
                blk.tr = A; blk.bl = A; blk.br = A;
            end else begin
                vsum = vote(E, G, A, B) + vote(F, K, A, B) + vote(H, N, A, B)
                       + vote(L, O, A, B);
                blk.tr = blend(A, B);
                blk.bl = blk.tr;
                blk.br = (vsum > 0) ? A : ((vsum < 0) ? B : blk.tr);
            end
        end else begin
            blk.tr = (A == C && A == F && B != E && B == J) ? A
                   : ((B == E && B == D && A != F && A == I) ? B : blend(A, B));
            blk.bl = (A == B && A == H && G != C && C == M) ? A
                   : ((C == G && C == D && A != H && A == I) ? C : blend(A, C));
            blk.br = blend(blend(A, B), blend(C, D));
        end
        if (wide) begin
            if (out_col == 0 || out_col + 1 >= wd) blk.bl = blend(A, C);
            blk.tr = '0;
            blk.br = '0;
        end else if (out_col == 0 || out_col + 2 >= wd) begin
            blk.tr = A; blk.bl = A; blk.br = A;
        end
        blk.eol = (out_col + 1 >= wd);
        blk.eof = blk.eol && (out_row + 1 >= ht);
        expected_blocks.push_back(blk);
        if (blk.eof) begin
            col_cnt = 0; row_cnt = 0; fill_cnt = 0; out_col = 0; out_row = 0;
        end else if (blk.eol) begin
            out_col = 0;
            out_row++;
        end else begin
            out_col++;
        end
    endtask

    task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        block_t blk;
        if (!rst_n) begin
            wide      = 1'b0;
            width_reg = px2x_pkg::WIDTH_RESET;
            lines_reg = px2x_pkg::LINES_RESET;
            mask_reg  = px2x_pkg::MASK_RESET;
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    win[r][c] = '0;
            col_cnt = 0; row_cnt = 0; fill_cnt = 0; out_col = 0; out_row = 0;
            expected_blocks.delete();
            pending <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    px2x_pkg::REG_WIDE_MODE:   wide      = cfg_data[0];
                    px2x_pkg::REG_LINE_WIDTH:  width_reg = cfg_data[9:0];
                    px2x_pkg::REG_FRAME_LINES: lines_reg = cfg_data[9:0];
                    px2x_pkg::REG_BLEND_MASK:  mask_reg  = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                predict_block(pixel, flush);
            if (out_valid && out_ready) begin
                if (expected_blocks.size() == 0) begin
                    $error("output word with no expected block");
                    errors++;
                end else begin
                    blk = expected_blocks.pop_front();
                    check_field("top_left", blk.tl, top_left);
                    check_field("top_right", blk.tr, top_right);
                    check_field("bottom_left", blk.bl, bottom_left);
                    check_field("bottom_right", blk.br, bottom_right);
                    check_field("end_of_line", 16'(blk.eol), 16'(end_of_line));
                    check_field("end_of_frame", 16'(blk.eof), 16'(end_of_frame));
                end
            end
            pending <= expected_blocks.size();
        end
    end

endmodule

[dv/pixel_art_2x_upscaler_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_art_2x_upscaler_unit_tb: testbench top for the 2x upscaler
// Streams whole frames under many register settings and idling patterns;
// the checker beside the block predicts every output block.
// ----------------------------------------------------------------------------
module pixel_art_2x_upscaler_unit_tb;

    localparam int CYCLE_LIMIT = 600000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = px2x_pkg::REG_WIDE_MODE;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [15:0] pixel = '0;
    logic        flush = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] top_left, top_right, bottom_left, bottom_right;
    logic        end_of_line, end_of_frame;
    int          errors;
    int          pending;

    int          send_idle = 0;
    int          recv_stall = 0;
    int          hold_cycles = 0;
    int          cycles = 0;
    int          rand_items = 0;
    logic [15:0] palette [4];

    pixel_art_2x_upscaler_unit dut (.*);

    px2x_block_checker chk (.*);

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("pixel_art_2x_upscaler_unit_tb failed");
            $finish;
        end
    end

    // receiver: long hold-off when requested, else random stalls
    always @(posedge clk) begin
        if (hold_cycles > 0) begin
            out_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic send_word(logic [15:0] p, logic f);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel    <= p;
        flush    <= f;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_regs(logic wm, logic [9:0] lw, logic [9:0] fl, logic [15:0] bm);
        cfg_we <= 1'b1; cfg_index <= px2x_pkg::REG_WIDE_MODE; cfg_data <= {15'd0, wm};
        @(posedge clk);
        cfg_index <= px2x_pkg::REG_LINE_WIDTH; cfg_data <= {6'd0, lw};
        @(posedge clk);
        cfg_index <= px2x_pkg::REG_FRAME_LINES; cfg_data <= {6'd0, fl};
        @(posedge clk);
        cfg_index <= px2x_pkg::REG_BLEND_MASK; cfg_data <= bm;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_pixel();
        if ($urandom_range(99) < 75) return palette[$urandom_range(3)];
        return 16'($urandom);
    endfunction

    // one frame: W*H pixels then 2W+2 drain words, with optional noise
    task automatic run_frame(int lw, int fl, bit noise, bit mid_pause);
        int wd;
        int ht;
        wd = (lw < 4) ? 4 : ((lw > px2x_pkg::LINE_MAX_DEF) ? px2x_pkg::LINE_MAX_DEF : lw);
        ht = (fl < 4) ? 4 : fl;
        for (int i = 0; i < wd * ht; i++) begin
            if (noise && $urandom_range(99) < 4) send_word(16'($urandom), 1'b1);
            if (mid_pause && i == wd * ht / 2) wait_idle();
            send_word(pick_pixel(), 1'b0);
            rand_items++;
        end
        for (int i = 0; i < 2 * wd + 2; i++) begin
            if (noise && $urandom_range(99) < 6) send_word(16'($urandom), 1'b0);
            else send_word(16'($urandom), 1'b1);
            rand_items++;
        end
        wait_idle();
    endtask

    task automatic set_phase(int ph);
        case (ph % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 52; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 52; end
            default: begin send_idle = 12; recv_stall = 12; end
        endcase
    endtask

    initial begin
        logic [15:0] bm;
        int          sel;
        int          lw;
        int          fl;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: smallest frame with a two-colour checker and two FFFF pixels on its diagonal,
        // a stray flush in the frame and a pixel among the drain words
        write_regs(1'b0, 10'd4, 10'd4, px2x_pkg::MASK_RESET);
        send_word(16'h1234, 1'b1);
        for (int i = 0; i < 16; i++)
            send_word((i == 5 || i == 10) ? 16'hFFFF :
                      (((i >> 2) + i) % 2 ? 16'h0000 : 16'hF81F), 1'b0);
        send_word(16'hABCD, 1'b0);
        for (int i = 0; i < 9; i++) send_word(16'h0000, 1'b1);
        wait_idle();

        // register extremes, saturated sizes among them
        palette[0] = 16'h0000; palette[1] = 16'hFFFF;
        palette[2] = 16'h07E0; palette[3] = 16'hF800;
        write_regs(1'b1, 10'd0, 10'd0, 16'h0000);
        run_frame(0, 0, 1'b1, 1'b0);
        write_regs(1'b0, 10'd3, 10'd5, 16'hFFFF);
        run_frame(3, 5, 1'b1, 1'b0);
        write_regs(1'b0, 10'd1023, 10'd4, px2x_pkg::MASK_RESET);
        run_frame(1023, 4, 1'b0, 1'b0);

        // pressure: long receiver hold-off with the sender running flat out
        set_phase(0);
        write_regs(1'b0, 10'd6, 10'd5, px2x_pkg::MASK_RESET);
        hold_cycles <= 400;
        run_frame(6, 5, 1'b0, 1'b1);

        rand_items = 0;
        for (int fr = 0; rand_items < 1250; fr++) begin
            set_phase(fr);
            for (int k = 0; k < 4; k++)
                palette[k] = 16'($urandom);
            if ($urandom_range(1)) palette[3] = palette[0];
            sel = $urandom_range(3);
            bm = (sel == 0) ? 16'h0000 : (sel == 1) ? 16'hFFFF :
                 (sel == 2) ? px2x_pkg::MASK_RESET : 16'($urandom);
            lw = int'($urandom_range(10, 4));
            fl = int'($urandom_range(7, 4));
            write_regs(1'($urandom), 10'(lw), 10'(fl), bm);
            run_frame(lw, fl, 1'b1, 1'b0);
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("pixel_art_2x_upscaler_unit_tb passed");
        else
            $display("pixel_art_2x_upscaler_unit_tb failed");
        $finish;
    end

endmodule
